@@ src/frt_pkg.sv @@
// Shared types, constants and helper functions for the three-channel
// free-running timer. No dependencies; every other file uses this package.
package frt_pkg;

  // Number of timer channels behind the register window.
  localparam int unsigned CHANNELS = 3;
  // Request lines kept internally, three per channel.
  localparam int unsigned REQ_W = 3 * CHANNELS;
  // Request lines visible on the result stream.
  localparam int unsigned IRQ_W = 9;
  // Width of the shared prescaler tick count.
  localparam int unsigned TICK_W = 5;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_IDLE  = 2'd3
  } op_e;

  // Register offsets inside one channel.
  localparam logic [3:0] OFF_CTRL    = 4'd0;
  localparam logic [3:0] OFF_STATUS  = 4'd1;
  localparam logic [3:0] OFF_CNT_HI  = 4'd2;
  localparam logic [3:0] OFF_CNT_LO  = 4'd3;
  localparam logic [3:0] OFF_CMPA_HI = 4'd4;
  localparam logic [3:0] OFF_CMPA_LO = 4'd5;
  localparam logic [3:0] OFF_CMPB_HI = 4'd6;
  localparam logic [3:0] OFF_CMPB_LO = 4'd7;
  localparam logic [3:0] OFF_CAP_HI  = 4'd8;
  localparam logic [3:0] OFF_CAP_LO  = 4'd9;

  // Command broadcast from the top level to every channel.
  typedef struct packed {
    logic              fire;
    op_e               op;
    logic [3:0]        offset;
    logic [7:0]        wdata;
    logic [7:0]        latch;
    logic [TICK_W-1:0] tick;
    logic              variant;
  } chan_cmd_t;

  // Answer of one channel for the transaction being processed.
  typedef struct packed {
    logic [7:0] rd_byte;
    logic [7:0] ld_byte;
    logic [2:0] req_next;
  } chan_rsp_t;

  // Prescaler mask chosen by the clock select bits and the variant register.
  function automatic logic [TICK_W-1:0] prescale_mask(input logic variant,
                                                      input logic [1:0] sel);
    logic [TICK_W-1:0] m;
    case (sel)
      2'd0:    m = TICK_W'(3);
      2'd1:    m = TICK_W'(7);
      2'd2:    m = TICK_W'(31);
      default: m = variant ? TICK_W'(3) : TICK_W'(1);
    endcase
    return m;
  endfunction

endpackage

@@ src/free_running_timer_16bit_x3.sv @@
// Top level of the three-channel 16-bit free-running timer with output compare.
// Depends on frt_pkg and instantiates one frt_channel per channel.
//
// Channel  Direction  Handshake                     Payload
// s_axis   in         s_axis_tvalid/s_axis_tready   tuser: operation; tdata: address, write_data
// m_axis   out        m_axis_tvalid/m_axis_tready   tdata: read_data, irq_requests
// cfg      in         cfg_valid_i/cfg_ready_o       cfg_data_i: prescale_variant
//
// Every transaction is first held in the input register; then the channel update and
// read mux load the result register.
// A new transaction is accepted every cycle while the result side keeps taking.
// When the result register is held by a stalled consumer, the input register
// still takes one more transaction; further input stalls until the result leaves.
// Reset is asynchronous; the input and result data registers are not reset.
module free_running_timer_16bit_x3 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] address, [15:8] write_data
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] read_data, [16:8] irq_requests, rest zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  // Input register.
  logic              in_valid_q;
  frt_pkg::op_e      in_op_q;
  logic [7:0]        in_addr_q;
  logic [7:0]        in_wdata_q;

  // Result register.
  logic              out_valid_q;
  logic [7:0]        out_rd_q, out_rd_d;
  logic [frt_pkg::IRQ_W-1:0] out_irq_q, out_irq_d;

  // Shared state: prescaler variant, byte latch and tick count.
  logic              variant_q;
  logic [7:0]        latch_q, latch_d;
  logic [frt_pkg::TICK_W-1:0] tick_q;

  logic              fire;
  logic              mapped;
  logic [3:0]        offset;
  logic              hi_offset;
  logic [frt_pkg::CHANNELS-1:0] sel;
  frt_pkg::chan_cmd_t           cmd;
  frt_pkg::chan_rsp_t           rsp [frt_pkg::CHANNELS];
  logic [frt_pkg::REQ_W-1:0]    req_all;
  logic [7:0]        chan_rd, chan_ld;

  // The item in the input register is processed when the result register is
  // free or being emptied in the same cycle.
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_irq_q, out_rd_q};
  assign cfg_ready_o   = 1'b1;

  assign offset    = in_addr_q[3:0];
  assign mapped    = |sel;
  assign hi_offset = (offset == frt_pkg::OFF_CNT_HI) || (offset == frt_pkg::OFF_CMPA_HI) ||
                     (offset == frt_pkg::OFF_CMPB_HI) || (offset == frt_pkg::OFF_CAP_HI);

  assign cmd.fire    = fire;
  assign cmd.op      = in_op_q;
  assign cmd.offset  = offset;
  assign cmd.wdata   = in_wdata_q;
  assign cmd.latch   = latch_q;
  assign cmd.tick    = tick_q;
  assign cmd.variant = variant_q;

  // One channel per address window; the high address nibble counts from one.
  for (genvar i = 0; i < frt_pkg::CHANNELS; i++) begin : g_chan
    assign sel[i] = (in_addr_q[7:4] == 4'(i + 1));
    assign req_all[3*i +: 3] = rsp[i].req_next;
    frt_channel u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .sel_i  (sel[i]),
      .cmd_i  (cmd),
      .rsp_o  (rsp[i])
    );
  end

  // Selects are one-hot or empty, so an OR over masked answers is the mux.
  always_comb begin
    chan_rd = 8'h00;
    chan_ld = 8'h00;
    for (int i = 0; i < int'(frt_pkg::CHANNELS); i++) begin
      chan_rd = chan_rd | (sel[i] ? rsp[i].rd_byte : 8'h00);
      chan_ld = chan_ld | (sel[i] ? rsp[i].ld_byte : 8'h00);
    end
  end

  always_comb begin
    latch_d  = latch_q;
    out_rd_d = 8'h00;
    case (in_op_q)
      frt_pkg::OP_READ: begin
        out_rd_d = mapped ? chan_rd : 8'hff;
        if (mapped && hi_offset) begin
          latch_d = chan_ld;
        end
      end
      frt_pkg::OP_WRITE: begin
        if (mapped && hi_offset) begin
          latch_d = in_wdata_q;
        end
      end
      default: ;
    endcase
    out_irq_d = frt_pkg::IRQ_W'(req_all);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q    <= frt_pkg::op_e'(s_axis_tuser);
      in_addr_q  <= s_axis_tdata[7:0];
      in_wdata_q <= s_axis_tdata[15:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_rd_q  <= out_rd_d;
      out_irq_q <= out_irq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= 1'b0;
      latch_q   <= '0;
      tick_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        variant_q <= cfg_data_i;
      end
      if (fire) begin
        latch_q <= latch_d;
        if (in_op_q == frt_pkg::OP_TICK) begin
          tick_q <= tick_q + frt_pkg::TICK_W'(1);
        end
      end
    end
  end

`ifndef ASSERT_OFF
  // A result waiting on a stalled consumer must never be overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !fire)
    else $error("result register overwritten while stalled");

  // The prescaler count steps exactly once per processed tick.
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_op_q == frt_pkg::OP_TICK)) |=>
      (tick_q == $past(tick_q) + frt_pkg::TICK_W'(1)))
    else $error("tick count did not advance on a tick");

  // Writes, ticks and unused operations return a zero data byte.
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_op_q != frt_pkg::OP_READ)) |=> (m_axis_tdata[7:0] == 8'h00))
    else $error("non-read transaction returned nonzero data");
`endif

endmodule

@@ src/frt_channel.sv @@
// One timer channel: control, status, counter, compare and capture registers.
// Depends on frt_pkg for the command and response structs.
module frt_channel (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sel_i,
  input  frt_pkg::chan_cmd_t  cmd_i,
  output frt_pkg::chan_rsp_t  rsp_o
);

  logic [7:0]  ctrl_q, ctrl_d;
  logic [3:0]  low_q, low_d;
  logic [2:0]  flag_q, flag_d;
  logic [2:0]  seen_q, seen_d;
  logic [2:0]  req_q, req_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] cmpa_q, cmpa_d;
  logic [15:0] cmpb_q, cmpb_d;
  logic [15:0] cap_q, cap_d;

  logic        rd_en, wr_en, step;
  logic        match_a, match_b, wrap;
  logic [2:0]  clr;
  logic [15:0] word;

  assign rd_en = cmd_i.fire && sel_i && (cmd_i.op == frt_pkg::OP_READ);
  assign wr_en = cmd_i.fire && sel_i && (cmd_i.op == frt_pkg::OP_WRITE);
  assign step  = cmd_i.fire && (cmd_i.op == frt_pkg::OP_TICK) &&
                 ((cmd_i.tick & frt_pkg::prescale_mask(cmd_i.variant, ctrl_q[1:0])) == '0);
  assign word    = {cmd_i.latch, cmd_i.wdata};
  assign match_a = (cnt_q == cmpa_q);
  assign match_b = (cnt_q == cmpb_q);
  assign clr     = ~cmd_i.wdata[6:4] & seen_q;

  always_comb begin
    ctrl_d = ctrl_q;
    low_d  = low_q;
    flag_d = flag_q;
    seen_d = seen_q;
    req_d  = req_q;
    cnt_d  = cnt_q;
    cmpa_d = cmpa_q;
    cmpb_d = cmpb_q;
    cap_d  = cap_q;
    wrap   = 1'b0;
    if (step) begin
      if (low_q[0] && match_a) begin
        cnt_d = '0;
      end else begin
        cnt_d = cnt_q + 16'd1;
        wrap  = (cnt_q == 16'hffff);
      end
      flag_d = flag_q | {match_b, match_a, wrap};
      req_d  = req_q | (ctrl_q[6:4] & flag_d);
    end
    if (wr_en) begin
      case (cmd_i.offset)
        frt_pkg::OFF_CTRL:    ctrl_d = cmd_i.wdata;
        frt_pkg::OFF_STATUS: begin
          // A flag clears only on a zero write after a read saw it set.
          low_d  = cmd_i.wdata[3:0];
          flag_d = flag_q & ~clr;
          seen_d = seen_q & ~clr;
          req_d  = req_q & ~clr;
        end
        frt_pkg::OFF_CNT_LO:  cnt_d  = word;
        frt_pkg::OFF_CMPA_LO: cmpa_d = word;
        frt_pkg::OFF_CMPB_LO: cmpb_d = word;
        frt_pkg::OFF_CAP_LO:  cap_d  = word;
        default:              ;
      endcase
    end
    if (rd_en && (cmd_i.offset == frt_pkg::OFF_STATUS)) begin
      seen_d = seen_q | flag_q;
    end
  end

  always_comb begin
    rsp_o.ld_byte  = 8'h00;
    rsp_o.req_next = req_d;
    case (cmd_i.offset)
      frt_pkg::OFF_CTRL:    rsp_o.rd_byte = ctrl_q;
      frt_pkg::OFF_STATUS:  rsp_o.rd_byte = {1'b0, flag_q, low_q};
      frt_pkg::OFF_CNT_HI: begin
        rsp_o.rd_byte = cnt_q[15:8];
        rsp_o.ld_byte = cnt_q[7:0];
      end
      frt_pkg::OFF_CMPA_HI: begin
        rsp_o.rd_byte = cmpa_q[15:8];
        rsp_o.ld_byte = cmpa_q[7:0];
      end
      frt_pkg::OFF_CMPB_HI: begin
        rsp_o.rd_byte = cmpb_q[15:8];
        rsp_o.ld_byte = cmpb_q[7:0];
      end
      frt_pkg::OFF_CAP_HI: begin
        rsp_o.rd_byte = cap_q[15:8];
        rsp_o.ld_byte = cap_q[7:0];
      end
      frt_pkg::OFF_CNT_LO, frt_pkg::OFF_CMPA_LO,
      frt_pkg::OFF_CMPB_LO, frt_pkg::OFF_CAP_LO: rsp_o.rd_byte = cmd_i.latch;
      default:              rsp_o.rd_byte = 8'hff;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      low_q  <= '0;
      flag_q <= '0;
      seen_q <= '0;
      req_q  <= '0;
      cnt_q  <= '0;
      cmpa_q <= 16'hffff;
      cmpb_q <= 16'hffff;
      cap_q  <= '0;
    end else begin
      ctrl_q <= ctrl_d;
      low_q  <= low_d;
      flag_q <= flag_d;
      seen_q <= seen_d;
      req_q  <= req_d;
      cnt_q  <= cnt_d;
      cmpa_q <= cmpa_d;
      cmpb_q <= cmpb_d;
      cap_q  <= cap_d;
    end
  end

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the three-channel free-running timer.
// Needs frt_pkg and free_running_timer_16bit_x3; a scoreboard class predicts every result.
`timescale 1ns / 100ps

module tb_top;
  import frt_pkg::*;

  // Longest wait that either side draws between two transactions.
  localparam int unsigned STALL_MAX = 18;
  // Cycles without any accepted transaction before the run is abandoned.
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // Random transactions issued under each prescaler variant.
  localparam int unsigned ITEMS_PER_PHASE = 340;
  // Quiet cycles after the last result.
  localparam int unsigned DRAIN_CYCLES = 8;
  // Status and control bit of the overflow flag; compare A and B follow it.
  localparam int unsigned FLAG_LSB = 4;
  // Status bit that makes a compare A match clear the counter.
  localparam int unsigned CLEAR_ON_A = 0;

  typedef struct packed {
    logic [7:0]       rd;
    logic [IRQ_W-1:0] irq;
  } timer_result_t;

  // Holds a private copy of every timer register and the results still owed.
  class timer_scoreboard;
    logic              variant;
    logic [7:0]        ctrl [CHANNELS];
    logic [7:0]        stat [CHANNELS];
    logic [15:0]       cnt  [CHANNELS];
    logic [15:0]       cmpa [CHANNELS];
    logic [15:0]       cmpb [CHANNELS];
    logic [15:0]       capv [CHANNELS];
    logic [3:0]        seen [CHANNELS];
    logic [7:0]        latch;
    logic [TICK_W-1:0] tick_cnt;
    logic [REQ_W-1:0]  req;
    timer_result_t     pending_q [$];
    int unsigned       errors, checked, n_reads, n_writes, n_ticks, n_other, n_irq;

    function void clear_state();
      variant  = 1'b0;
      latch    = '0;
      tick_cnt = '0;
      req      = '0;
      for (int i = 0; i < CHANNELS; i++) begin
        ctrl[i] = '0;
        stat[i] = '0;
        cnt[i]  = '0;
        cmpa[i] = 16'hFFFF;
        cmpb[i] = 16'hFFFF;
        capv[i] = '0;
        seen[i] = '0;
      end
    endfunction

    function void set_variant(logic v);
      variant = v;
    endfunction

    // One prescaled step of a channel on a timer tick.
    function void advance_channel(int unsigned ch);
      logic [TICK_W-1:0] mask;
      logic hit_a, hit_b;
      int unsigned k;
      case (ctrl[ch][1:0])
        2'd0:    mask = 5'd3;
        2'd1:    mask = 5'd7;
        2'd2:    mask = 5'd31;
        default: mask = variant ? 5'd3 : 5'd1;
      endcase
      if ((tick_cnt & mask) != '0) return;
      hit_a = (cnt[ch] == cmpa[ch]);
      hit_b = (cnt[ch] == cmpb[ch]);
      if (stat[ch][CLEAR_ON_A] && hit_a) begin
        cnt[ch] = '0;
      end else begin
        cnt[ch] = cnt[ch] + 16'd1;
        if (cnt[ch] == 16'd0) stat[ch][FLAG_LSB] = 1'b1;
      end
      if (hit_a) stat[ch][FLAG_LSB+1] = 1'b1;
      if (hit_b) stat[ch][FLAG_LSB+2] = 1'b1;
      for (k = 0; k < 3; k++) begin
        if (ctrl[ch][FLAG_LSB+k] && stat[ch][FLAG_LSB+k]) req[ch*3+k] = 1'b1;
      end
    endfunction

    function logic [7:0] read_reg(int unsigned ch, logic [3:0] off);
      case (off)
        OFF_CTRL: return ctrl[ch];
        OFF_STATUS: begin
          seen[ch] = seen[ch] | stat[ch][7:4];
          return stat[ch];
        end
        OFF_CNT_HI:  begin latch = cnt[ch][7:0];  return cnt[ch][15:8];  end
        OFF_CMPA_HI: begin latch = cmpa[ch][7:0]; return cmpa[ch][15:8]; end
        OFF_CMPB_HI: begin latch = cmpb[ch][7:0]; return cmpb[ch][15:8]; end
        OFF_CAP_HI:  begin latch = capv[ch][7:0]; return capv[ch][15:8]; end
        OFF_CNT_LO, OFF_CMPA_LO, OFF_CMPB_LO, OFF_CAP_LO: return latch;
        default: return 8'hFF;
      endcase
    endfunction

    function void write_reg(int unsigned ch, logic [3:0] off, logic [7:0] d);
      logic [15:0] word;
      int unsigned k;
      word = {latch, d};
      case (off)
        OFF_CTRL: ctrl[ch] = d;
        OFF_STATUS: begin
          stat[ch][3:0] = d[3:0];
          // A flag only drops when it was seen set by an earlier status read.
          for (k = 0; k < 3; k++) begin
            if (!d[FLAG_LSB+k] && seen[ch][k]) begin
              stat[ch][FLAG_LSB+k] = 1'b0;
              seen[ch][k] = 1'b0;
              req[ch*3+k] = 1'b0;
            end
          end
        end
        OFF_CNT_HI, OFF_CMPA_HI, OFF_CMPB_HI, OFF_CAP_HI: latch = d;
        OFF_CNT_LO:  cnt[ch]  = word;
        OFF_CMPA_LO: cmpa[ch] = word;
        OFF_CMPB_LO: cmpb[ch] = word;
        OFF_CAP_LO:  capv[ch] = word;
        default: ;
      endcase
    endfunction

    // Called for every accepted input transaction; queues the result it owes.
    function void note_access(op_e op, logic [7:0] addr, logic [7:0] wdata);
      timer_result_t res;
      logic mapped;
      int unsigned i;
      mapped = (addr[7:4] >= 4'd1) && (addr[7:4] <= 4'(CHANNELS));
      res.rd = 8'h00;
      case (op)
        OP_READ: begin
          n_reads++;
          res.rd = mapped ? read_reg(int'(addr[7:4]) - 1, addr[3:0]) : 8'hFF;
        end
        OP_WRITE: begin
          n_writes++;
          if (mapped) write_reg(int'(addr[7:4]) - 1, addr[3:0], wdata);
        end
        OP_TICK: begin
          n_ticks++;
          for (i = 0; i < CHANNELS; i++) advance_channel(i);
          tick_cnt = tick_cnt + 1'b1;
        end
        default: n_other++;
      endcase
      res.irq = req[IRQ_W-1:0];
      if (res.irq != '0) n_irq++;
      pending_q.push_back(res);
    endfunction

    // Called for every accepted output transaction.
    function void check_result(logic [23:0] word);
      timer_result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result expected none, got %06h", $time, word);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (word[7:0] !== want.rd) begin
        errors++;
        $display("%0t: read_data expected %02h, got %02h", $time, want.rd, word[7:0]);
      end
      if (word[16:8] !== want.irq) begin
        errors++;
        $display("%0t: irq_requests expected %03h, got %03h", $time, want.irq, word[16:8]);
      end
      if (word[23:17] !== 7'd0) begin
        errors++;
        $display("%0t: tdata padding expected 00, got %02h", $time, word[23:17]);
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i    = 1'b0;

  timer_scoreboard sb = new;
  int unsigned items_sent  = 0;
  int unsigned quiet_count = 0;
  // When set, that side issues transactions back to back.
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  free_running_timer_16bit_x3 dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned draw_gap(bit calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, STALL_MAX);
  endfunction

  function automatic logic [7:0] chan_addr(int unsigned ch, logic [3:0] off);
    return {4'(ch + 1), off};
  endfunction

  // Monitors all three channels at the clock edge and runs the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_access(op_e'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[15:8]);
      if (cfg_valid_i && cfg_ready_o) sb.set_variant(cfg_data_i);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_count = 0;
      end else begin
        quiet_count++;
      end
      if (quiet_count >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_count);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // Result side: stalls a random number of cycles before taking each result.
  initial begin
    int unsigned gap;
    forever begin
      gap = draw_gap(rx_calm);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && rst_ni));
    end
  end

  // Issues one input transaction and returns at the edge where it is taken.
  task automatic send_item(input op_e op, input logic [7:0] addr, input logic [7:0] data);
    int unsigned gap;
    gap = draw_gap(tx_calm);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {data, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op != OP_IDLE) items_sent++;
  endtask

  task automatic write16(input int unsigned ch, input logic [3:0] hi_off,
                         input logic [15:0] value);
    send_item(OP_WRITE, chan_addr(ch, hi_off), value[15:8]);
    send_item(OP_WRITE, chan_addr(ch, hi_off + 4'd1), value[7:0]);
  endtask

  // Waits until the block has drained, then writes the prescaler variant.
  task automatic write_variant(input logic v);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Random traffic, mostly short register sequences that drive the counters
  // into compare matches and overflow, plus flag clearing and plain noise.
  task automatic run_random(input int unsigned count);
    int unsigned target, ch, n;
    logic [15:0] base;
    logic [7:0]  d;
    logic [1:0]  sel;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 15) == 0) tx_calm = $urandom_range(0, 2) == 0;
      if ($urandom_range(0, 15) == 0) rx_calm = $urandom_range(0, 2) == 0;
      ch = $urandom_range(0, CHANNELS - 1);
      // Fast clock selects keep the counters moving within a few ticks.
      sel = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3))
                                        : (($urandom_range(0, 1) == 1) ? 2'd3 : 2'd0);
      case ($urandom_range(0, 9))
        0, 1: begin
          // Arm a channel: counter a few steps short of both compares.
          base = ($urandom_range(0, 1) == 1) ? (16'hFFF0 | 16'($urandom_range(0, 15)))
                                             : 16'($urandom);
          write16(ch, OFF_CMPA_HI, base + 16'($urandom_range(0, 6)));
          write16(ch, OFF_CMPB_HI, base + 16'($urandom_range(0, 6)));
          write16(ch, OFF_CNT_HI, base);
          send_item(OP_WRITE, chan_addr(ch, OFF_CTRL), (8'($urandom) & 8'hFC) | sel);
          send_item(OP_WRITE, chan_addr(ch, OFF_STATUS), 8'($urandom));
        end
        2, 3, 4: begin
          n = $urandom_range(1, 24);
          repeat (n) send_item(OP_TICK, 8'($urandom), 8'($urandom));
        end
        5: begin
          // Read the flags, then write zeros to some of them.
          send_item(OP_READ, chan_addr(ch, OFF_STATUS), 8'($urandom));
          d = 8'($urandom);
          if ($urandom_range(0, 1) == 1) d = d & 8'h8F;
          send_item(OP_WRITE, chan_addr(ch, OFF_STATUS), d);
        end
        6: begin
          d = 8'($urandom_range(0, 3));
          send_item(OP_READ, chan_addr(ch, OFF_CNT_HI + 4'(2 * d)), 8'($urandom));
          send_item(OP_READ, chan_addr(ch, OFF_CNT_LO + 4'(2 * d)), 8'($urandom));
        end
        7: send_item(OP_WRITE, chan_addr(ch, OFF_CTRL), (8'($urandom) & 8'hFC) | sel);
        8: send_item(($urandom_range(0, 1) == 1) ? OP_WRITE : OP_READ,
                     chan_addr(ch, 4'($urandom)), 8'($urandom));
        default: send_item(op_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    sb.clear_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_variant(1'b0);

    // Directed part: unmapped channels and offsets, the unused operation.
    send_item(OP_READ, 8'h00, 8'h00);
    send_item(OP_READ, 8'hFF, 8'hFF);
    send_item(OP_WRITE, {4'd4, OFF_CTRL}, 8'hFF);
    send_item(OP_IDLE, 8'hFF, 8'hFF);
    send_item(OP_READ, chan_addr(0, 4'hA), 8'h00);
    send_item(OP_WRITE, chan_addr(2, 4'hF), 8'hAA);
    // High byte read loads the latch; the low byte read answers from it.
    send_item(OP_READ, chan_addr(0, OFF_CMPA_HI), 8'h00);
    send_item(OP_READ, chan_addr(0, OFF_CMPA_LO), 8'h00);
    // Counter just below compare A, clear on A, fastest clock, all enables.
    write16(0, OFF_CNT_HI, 16'hFFFE);
    send_item(OP_WRITE, chan_addr(0, OFF_CTRL), 8'h73);
    send_item(OP_WRITE, chan_addr(0, OFF_STATUS), 8'h01);
    repeat (4) send_item(OP_TICK, 8'h00, 8'h00);
    // Enables off: the request lines must stay up until the flags clear.
    send_item(OP_WRITE, chan_addr(0, OFF_CTRL), 8'h03);
    send_item(OP_TICK, 8'hFF, 8'hFF);
    send_item(OP_READ, chan_addr(0, OFF_STATUS), 8'h00);
    send_item(OP_WRITE, chan_addr(0, OFF_STATUS), 8'h0E);
    // Low byte write pairs with whatever the latch holds.
    send_item(OP_READ, chan_addr(2, OFF_CAP_HI), 8'h00);
    send_item(OP_WRITE, chan_addr(2, OFF_CAP_LO), 8'hFF);
    send_item(OP_READ, chan_addr(2, OFF_CAP_HI), 8'h00);
    send_item(OP_READ, chan_addr(2, OFF_CAP_LO), 8'h00);

    write_variant(1'b1);
    run_random(ITEMS_PER_PHASE);
    write_variant(1'b0);
    run_random(ITEMS_PER_PHASE);
    write_variant(1'b1);
    run_random(ITEMS_PER_PHASE);

    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb_top: %0d reads, %0d writes, %0d ticks, %0d unused-op transactions",
             sb.n_reads, sb.n_writes, sb.n_ticks, sb.n_other);
    $display("tb_top: %0d results checked under both prescaler variants, %0d with requests",
             sb.checked, sb.n_irq);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
